[src/lewe_pkg.sv]
// ----------------------------------------------------------------------------
// Line editor package
// Shared constants and types for the line editor with word erase.
// ----------------------------------------------------------------------------
package lewe_pkg;

  localparam int LINE_DEPTH_DEFAULT = 64;

  localparam logic [6:0] WIDTH_RESET = 7'd40;

  localparam logic [7:0] KEY_EOF    = 8'd4;
  localparam logic [7:0] KEY_KILL   = 8'd21;
  localparam logic [7:0] KEY_WERASE = 8'd23;
  localparam logic [7:0] KEY_ERASE  = 8'd127;
  localparam logic [7:0] PRINT_LOW  = 8'd32;
  localparam logic [7:0] PRINT_HIGH = 8'd126;
  localparam logic [6:0] SPACE_CHAR = 7'd32;

  localparam logic [2:0] ACT_ECHO    = 3'd0;
  localparam logic [2:0] ACT_NL_ECHO = 3'd1;
  localparam logic [2:0] ACT_ERASE   = 3'd2;
  localparam logic [2:0] ACT_BELL    = 3'd3;
  localparam logic [2:0] ACT_EOF     = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

[src/lewe_store.sv]
// ----------------------------------------------------------------------------
// Line store
// Single-port-write, single-port-read memory holding the edit line, with a
// registered read.
// ----------------------------------------------------------------------------
module lewe_store #(
  parameter int DEPTH = lewe_pkg::LINE_DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [6:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [6:0]    rd_data
);

  logic [6:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[src/line_editor_with_word_erase.sv]
// ----------------------------------------------------------------------------
// Line editor with word erase
// Keeps an edit line of keyboard characters and reports one action for
// each received byte.
//
// Input transactions carry key_byte on key_valid; the block drives
// key_stall. Each accepted byte yields exactly one result transaction on
// res_valid with action, echo_char, erase_count and line_length; the
// receiver drives res_stall. The line width register is written through
// cfg_wen and cfg_wdata; the user must do so only while the block is idle,
// which the block does not enforce. Printable bytes, erase, kill, end of
// input and bell codes give their result in the cycle after acceptance.
// A word erase walks back through the line store one character per cycle
// through its single read port and stops at a space in front of the word
// or at the start of the line. The next byte is accepted once the previous
// result is in the output register and is being taken or has been taken.
// While the receiver stalls, the result is held and no new byte is taken.
// Reset clears the line, sets the width to 40 and empties the output
// register; the store contents need no clearing.
// ----------------------------------------------------------------------------
module line_editor_with_word_erase #(
  parameter int LINE_DEPTH = lewe_pkg::LINE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic [6:0] cfg_wdata,
  input  logic       key_valid,
  output logic       key_stall,
  input  logic [7:0] key_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [2:0] action,
  output logic [6:0] echo_char,
  output logic [6:0] erase_count,
  output logic [6:0] line_length
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int FW = $clog2(LINE_DEPTH + 1);

  lewe_pkg::state_t state, state_next;

  logic [FW-1:0] fill, fill_next;
  logic [FW-1:0] cnt, cnt_next;
  logic          word_phase, word_phase_next;
  logic [6:0]    width;

  logic          load_out;
  logic [2:0]    action_next;
  logic [6:0]    echo_next;
  logic [FW-1:0] erase_next;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [6:0]    rd_data;

  logic          accept;
  logic          is_print;
  logic          room;
  logic [6:0]    width_min;
  logic          scan_dec;
  logic          scan_done;

  lewe_store #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (key_byte[6:0]),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign key_stall = !((state == lewe_pkg::ST_IDLE) && (!res_valid || !res_stall));
  assign accept    = key_valid && !key_stall;
  assign is_print  = (key_byte >= lewe_pkg::PRINT_LOW) && (key_byte <= lewe_pkg::PRINT_HIGH);
  assign width_min = (width == 7'd0) ? 7'd1 : width;
  assign room      = (32'(fill) < 32'(width_min)) && (32'(fill) < LINE_DEPTH);

  // During the scan the registered read data is the character at fill - 1.
  assign scan_dec  = !word_phase || (rd_data != lewe_pkg::SPACE_CHAR);
  assign scan_done = !scan_dec || (fill == FW'(1));

  // The read address looks one character further back when this cycle
  // removes one, so the scan never waits on the memory.
  assign rd_addr = AW'(fill - FW'(1) - FW'(scan_dec && (state == lewe_pkg::ST_SCAN)));

  always_comb begin
    state_next = state;
    unique case (state)
      lewe_pkg::ST_IDLE: begin
        if (accept && (key_byte == lewe_pkg::KEY_WERASE) && (fill != '0)) begin
          state_next = lewe_pkg::ST_SCAN;
        end
      end
      lewe_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = lewe_pkg::ST_IDLE;
        end
      end
      default: state_next = lewe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    fill_next       = fill;
    cnt_next        = cnt;
    word_phase_next = word_phase;
    load_out        = 1'b0;
    action_next     = lewe_pkg::ACT_BELL;
    echo_next       = 7'd0;
    erase_next      = '0;
    wr_en           = 1'b0;
    wr_addr         = AW'(fill);
    unique case (state)
      lewe_pkg::ST_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          if ((key_byte == lewe_pkg::KEY_EOF) && (fill == '0)) begin
            action_next = lewe_pkg::ACT_EOF;
          end else if (is_print) begin
            wr_en     = 1'b1;
            echo_next = key_byte[6:0];
            if (room) begin
              action_next = lewe_pkg::ACT_ECHO;
              fill_next   = fill + FW'(1);
            end else begin
              action_next = lewe_pkg::ACT_NL_ECHO;
              wr_addr     = '0;
              fill_next   = FW'(1);
            end
          end else if (key_byte == lewe_pkg::KEY_ERASE) begin
            if (fill != '0) begin
              action_next = lewe_pkg::ACT_ERASE;
              erase_next  = FW'(1);
              fill_next   = fill - FW'(1);
            end
          end else if (key_byte == lewe_pkg::KEY_KILL) begin
            action_next = lewe_pkg::ACT_ERASE;
            erase_next  = fill;
            fill_next   = '0;
          end else if (key_byte == lewe_pkg::KEY_WERASE) begin
            action_next = lewe_pkg::ACT_ERASE;
            if (fill != '0) begin
              load_out        = 1'b0;
              cnt_next        = '0;
              word_phase_next = 1'b0;
            end
          end
        end
      end
      lewe_pkg::ST_SCAN: begin
        if (scan_dec) begin
          fill_next = fill - FW'(1);
          cnt_next  = cnt + FW'(1);
        end
        word_phase_next = word_phase || (rd_data != lewe_pkg::SPACE_CHAR);
        if (scan_done) begin
          load_out    = 1'b1;
          action_next = lewe_pkg::ACT_ERASE;
          erase_next  = cnt + FW'(scan_dec);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lewe_pkg::ST_IDLE;
      fill      <= '0;
      width     <= lewe_pkg::WIDTH_RESET;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (cfg_wen) begin
        width <= cfg_wdata;
      end
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt        <= cnt_next;
    word_phase <= word_phase_next;
    if (load_out) begin
      action      <= action_next;
      echo_char   <= echo_next;
      erase_count <= 7'(erase_next);
      line_length <= 7'(fill_next);
    end
  end

endmodule

[src/lewe_checker.sv]
// ----------------------------------------------------------------------------
// Line editor checker
// Port-level assertions for the line editor, bound to its top level.
// ----------------------------------------------------------------------------
module lewe_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic [2:0] action,
  input logic [6:0] echo_char,
  input logic [6:0] erase_count,
  input logic [6:0] line_length
);

  // A stalled result transaction keeps its contents.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(action) && $stable(echo_char)
      && $stable(erase_count) && $stable(line_length))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result pending after reset");

  // Only echo actions carry a character and only erase carries a count.
  a_fields_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((action == lewe_pkg::ACT_ECHO || action == lewe_pkg::ACT_NL_ECHO)
      || echo_char == 7'd0) && (action == lewe_pkg::ACT_ERASE || erase_count == 7'd0))
    else $error("unused result field not zero");

  // A wrapped line holds just the new character.
  a_wrap_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && action == lewe_pkg::ACT_NL_ECHO |-> line_length == 7'd1)
    else $error("line length wrong after wrap");

  // End of input is only reported on an empty line.
  a_eof_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && action == lewe_pkg::ACT_EOF |-> line_length == 7'd0)
    else $error("end of input on a non-empty line");

endmodule

bind line_editor_with_word_erase lewe_checker u_lewe_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .action      (action),
  .echo_char   (echo_char),
  .erase_count (erase_count),
  .line_length (line_length)
);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Line editor with word erase testbench
// Drives keyboard bytes through the valid/stall input channel and checks
// every result transaction against a line editor predictor. The predictor
// keeps its own copy of the line and of the width register. The run starts
// with a short directed sequence and then steps the line width through its
// extremes and random values. Each width setting is followed by a batch of
// random bytes, mostly words, spaces and erase keys with some noise. Both
// channels idle in random bursts, and the final batch runs without idling.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH = lewe_pkg::LINE_DEPTH_DEFAULT;
  localparam int PHASES = 16;
  localparam int PHASE_KEYS = 100;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [2:0] act;
    logic [6:0] echo;
    logic [6:0] erased;
    logic [6:0] length;
  } editor_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wen = 1'b0;
  logic [6:0] cfg_wdata = 7'd0;
  logic       key_valid = 1'b0;
  logic       key_stall;
  logic [7:0] key_byte = 8'd0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [2:0] action;
  logic [6:0] echo_char;
  logic [6:0] erase_count;
  logic [6:0] line_length;

  logic [7:0]     key_queue[$];
  editor_result_t pending_results[$];
  editor_result_t want;
  editor_result_t got;

  logic [6:0] line_chars[DEPTH];
  int         line_fill = 0;
  int         width_setting = lewe_pkg::WIDTH_RESET;

  logic key_taken = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   send_odds = 6;
  int   stall_odds = 6;
  int   failures = 0;
  int   cycles = 0;
  int   width_steps[8] = '{1, 0, 64, 127, 40, 3, 63, 65};

  line_editor_with_word_erase #(
    .LINE_DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .key_valid(key_valid),
    .key_stall(key_stall),
    .key_byte(key_byte),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .action(action),
    .echo_char(echo_char),
    .erase_count(erase_count),
    .line_length(line_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic editor_result_t edit_line(input logic [7:0] key);
    editor_result_t res;
    int eff;
    res = '0;
    eff = width_setting;
    if (eff < 1) eff = 1;
    if (eff > DEPTH) eff = DEPTH;
    if (key == lewe_pkg::KEY_EOF && line_fill == 0) begin
      res.act = lewe_pkg::ACT_EOF;
    end else if (key >= lewe_pkg::PRINT_LOW && key <= lewe_pkg::PRINT_HIGH) begin
      if (line_fill < eff) begin
        res.act = lewe_pkg::ACT_ECHO;
      end else begin
        res.act = lewe_pkg::ACT_NL_ECHO;
        line_fill = 0;
      end
      line_chars[line_fill] = key[6:0];
      line_fill++;
      res.echo = key[6:0];
    end else if (key == lewe_pkg::KEY_ERASE) begin
      if (line_fill > 0) begin
        line_fill--;
        res.act = lewe_pkg::ACT_ERASE;
        res.erased = 7'd1;
      end else begin
        res.act = lewe_pkg::ACT_BELL;
      end
    end else if (key == lewe_pkg::KEY_KILL) begin
      res.act = lewe_pkg::ACT_ERASE;
      res.erased = line_fill[6:0];
      line_fill = 0;
    end else if (key == lewe_pkg::KEY_WERASE) begin
      res.act = lewe_pkg::ACT_ERASE;
      while (line_fill > 0 && line_chars[line_fill - 1] == lewe_pkg::SPACE_CHAR) begin
        line_fill--;
        res.erased++;
      end
      while (line_fill > 0 && line_chars[line_fill - 1] != lewe_pkg::SPACE_CHAR) begin
        line_fill--;
        res.erased++;
      end
    end else begin
      res.act = lewe_pkg::ACT_BELL;
    end
    res.length = line_fill[6:0];
    return res;
  endfunction

  function automatic logic [7:0] random_key(input bit grow);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < (grow ? 78 : 50)) return 8'($urandom_range(33, 126));
    if (pick < (grow ? 90 : 64)) return {1'b0, lewe_pkg::SPACE_CHAR};
    if (pick < (grow ? 93 : 72)) return lewe_pkg::KEY_ERASE;
    if (pick < (grow ? 96 : 80)) return lewe_pkg::KEY_WERASE;
    if (pick < (grow ? 96 : 83)) return lewe_pkg::KEY_KILL;
    if (pick < (grow ? 98 : 87)) return lewe_pkg::KEY_EOF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic wait_until_drained();
    @(posedge clk);
    while (key_queue.size() != 0 || key_valid || pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_line_width(input int value);
    wait_until_drained();
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value[6:0];
    width_setting = value;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (key_valid && !key_taken) begin
      key_valid <= 1'b1;
    end else if (gap_left > 0) begin
      key_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (key_queue.size() != 0 && send_odds != 0 &&
                 $urandom_range(1, send_odds) == 1) begin
      key_valid <= 1'b0;
      gap_left <= $urandom_range(0, 15);
    end else if (key_queue.size() != 0) begin
      key_valid <= 1'b1;
      key_byte <= key_queue.pop_front();
    end else begin
      key_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      res_stall <= 1'b1;
      stall_left <= $urandom_range(0, 15);
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      key_taken <= 1'b0;
    end else begin
      key_taken <= key_valid && !key_stall;
      if (res_valid && !res_stall) begin
        got = '{action, echo_char, erase_count, line_length};
        if (pending_results.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("Unexpected result: action %0d echo %0d erase %0d length %0d",
                     got.act, got.echo, got.erased, got.length);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.act !== want.act || got.echo !== want.echo ||
              got.erased !== want.erased || got.length !== want.length) begin
            failures++;
            if (failures <= 10) begin
              $display("Mismatch: expected action %0d echo %0d erase %0d length %0d",
                       want.act, want.echo, want.erased, want.length);
              $display("          actual   action %0d echo %0d erase %0d length %0d",
                       got.act, got.echo, got.erased, got.length);
            end
          end
        end
      end
      if (key_valid && !key_stall) begin
        pending_results.push_back(edit_line(key_byte));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL line_editor_with_word_erase");
      $finish;
    end
  end

  initial begin
    int  next_width;
    bit  grow;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    key_queue = '{lewe_pkg::KEY_EOF, lewe_pkg::KEY_ERASE, lewe_pkg::KEY_KILL,
                  lewe_pkg::KEY_WERASE, 8'd0, 8'd255, 8'd128, 8'd31, 8'd32, 8'd97,
                  lewe_pkg::PRINT_HIGH, 8'd98, 8'd32, 8'd32, lewe_pkg::KEY_WERASE,
                  lewe_pkg::KEY_EOF, 8'd99, lewe_pkg::KEY_ERASE, lewe_pkg::KEY_KILL,
                  8'd113, 8'd114, 8'd115, 8'd116};
    set_line_width(2);
    key_queue = '{8'd117, 8'd118, 8'd119};

    for (int p = 0; p < PHASES; p++) begin
      next_width = (p < 8) ? width_steps[p] : $urandom_range(0, 127);
      set_line_width(next_width);
      grow = (next_width >= 64) || (next_width >= 20 && $urandom_range(0, 1) == 1);
      if (p == PHASES - 1) begin
        send_odds = 0;
        stall_odds = 0;
      end else begin
        send_odds = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(2, 12);
        stall_odds = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(2, 12);
      end
      repeat (PHASE_KEYS) key_queue.push_back(random_key(grow));
    end

    wait_until_drained();
    repeat (DEPTH + 16) @(posedge clk);
    failures += pending_results.size();
    if (failures == 0) begin
      $display("PASS line_editor_with_word_erase");
    end else begin
      $display("FAIL line_editor_with_word_erase");
    end
    $finish;
  end

endmodule

[filelist.f]
src/lewe_pkg.sv
src/lewe_store.sv
src/line_editor_with_word_erase.sv
src/lewe_checker.sv
sim/testbench.sv
